### hdl/rre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rre_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 24;
    localparam int COEF_WIDTH_DEF     = 32;
    localparam int INTERNAL_WIDTH_DEF = 40;

    localparam int NUM_REGS    = 7;
    localparam int REG_INDEX_W = 3;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_FIRST_B0    = 3'd0,
        REG_FIRST_B1    = 3'd1,
        REG_FIRST_A1    = 3'd2,
        REG_SECOND_B0   = 3'd3,
        REG_SECOND_B1   = 3'd4,
        REG_SECOND_A1   = 3'd5,
        REG_OUTPUT_GAIN = 3'd6
    } reg_idx_t;

    // multiplier operand sources
    typedef enum logic [2:0] {
        OPD_X,
        OPD_XP,
        OPD_Y1P,
        OPD_Y2P,
        OPD_Y1,
        OPD_Y2
    } opd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic issue;
        logic hi;
        logic neg;
        logic first;
    } mac_ctl_t;

    typedef struct packed {
        mac_ctl_t mac;
        reg_idx_t coef_sel;
        opd_t     opd_sel;
        logic     store_y1;
        logic     store_y2;
        logic     store_res;
        logic     chan;
        logic     commit;
    } seq_ctl_t;

endpackage

`default_nettype wire

### hdl/rre_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module rre_cfg #(
    parameter int COEF_WIDTH = rre_pkg::COEF_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               we,
    input  wire logic [rre_pkg::REG_INDEX_W-1:0]    index,
    input  wire logic [COEF_WIDTH-1:0]              data,
    input  wire rre_pkg::reg_idx_t                  sel,
    output logic signed [COEF_WIDTH-1:0]            coef
);

    logic [COEF_WIDTH-1:0] coef_reg [rre_pkg::NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rre_pkg::NUM_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (we && (index <= rre_pkg::REG_INDEX_W'(rre_pkg::NUM_REGS - 1)))
        begin
            coef_reg[index] <= data;
        end
    end

    assign coef = signed'(coef_reg[sel]);

endmodule

`default_nettype wire

### hdl/rre_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module rre_mac #(
    parameter int SAMPLE_WIDTH   = rre_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH     = rre_pkg::COEF_WIDTH_DEF,
    parameter int INTERNAL_WIDTH = rre_pkg::INTERNAL_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire rre_pkg::mac_ctl_t                 op,
    input  wire logic signed [COEF_WIDTH-1:0]      coef,
    input  wire logic signed [INTERNAL_WIDTH-1:0]  opd,
    output logic signed [INTERNAL_WIDTH-1:0]       y_int,
    output logic signed [SAMPLE_WIDTH-1:0]         y_smp
);

    localparam int HALF  = INTERNAL_WIDTH / 2;
    localparam int HI_W  = INTERNAL_WIDTH - HALF;
    localparam int BW    = HI_W + 1;
    localparam int PW    = COEF_WIDTH + BW;
    localparam int ACC_W = COEF_WIDTH + INTERNAL_WIDTH + 2;
    localparam int CF    = COEF_WIDTH - 5;
    localparam int SH_W  = ACC_W - CF;
    localparam logic [ACC_W-1:0] RND = {{(ACC_W-1){1'b0}}, 1'b1} << (CF - 1);

    logic signed [BW-1:0]  bpart;
    logic signed [PW-1:0]  prod;
    logic signed [PW-1:0]  prod_reg;
    logic                  pv_reg;
    logic                  ph_reg;
    logic                  pn_reg;
    logic                  pf_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic [ACC_W-1:0]      acc_next;
    logic signed [ACC_W-1:0] ext;
    logic [ACC_W-1:0]      term;
    logic [ACC_W-1:0]      rnd_sum;
    logic [SH_W-1:0]       shd;
    logic [SH_W-INTERNAL_WIDTH:0] top_i;
    logic [SH_W-SAMPLE_WIDTH:0]   top_s;

    // operand split in two halves: low half unsigned, high half signed
    always_comb
    begin
        if (op.hi)
        begin
            bpart = BW'(signed'(opd[INTERNAL_WIDTH-1:HALF]));
        end
        else
        begin
            bpart = signed'(BW'(opd[HALF-1:0]));
        end
        prod = coef * bpart;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            ph_reg <= 1'b0;
            pn_reg <= 1'b0;
            pf_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= op.issue;
            ph_reg <= op.hi;
            pn_reg <= op.neg;
            pf_reg <= op.first;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        if (pv_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        ext = ACC_W'(prod_reg);
        if (ph_reg)
        begin
            ext = ext <<< HALF;
        end
        term = pn_reg ? ~ext : ext;
        acc_next = (pf_reg ? '0 : acc_reg) + term + ACC_W'(pn_reg);
    end

    // round half up, drop coefficient fraction, saturate
    always_comb
    begin
        rnd_sum = acc_reg + RND;
        shd     = rnd_sum[ACC_W-1:CF];
        top_i   = shd[SH_W-1:INTERNAL_WIDTH-1];
        top_s   = shd[SH_W-1:SAMPLE_WIDTH-1];
        if ((&top_i) || !(|top_i))
        begin
            y_int = signed'(shd[INTERNAL_WIDTH-1:0]);
        end
        else
        begin
            y_int = signed'({shd[SH_W-1], {(INTERNAL_WIDTH-1){~shd[SH_W-1]}}});
        end
        if ((&top_s) || !(|top_s))
        begin
            y_smp = signed'(shd[SAMPLE_WIDTH-1:0]);
        end
        else
        begin
            y_smp = signed'({shd[SH_W-1], {(SAMPLE_WIDTH-1){~shd[SH_W-1]}}});
        end
    end

endmodule

`default_nettype wire

### hdl/rre_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rre_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_fire,
    input  wire logic           slot_free,
    output logic                in_ready,
    output rre_pkg::seq_ctl_t   ctl
);

    localparam int STEP_LAST = 17;
    localparam int STEP_W    = $clog2(STEP_LAST + 1);

    rre_pkg::state_t    state_reg;
    rre_pkg::state_t    state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic               chan_reg;
    logic               chan_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rre_pkg::ST_IDLE;
            step_reg  <= '0;
            chan_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            chan_reg  <= chan_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        chan_next    = chan_reg;
        in_ready     = 1'b0;
        ctl          = '0;
        ctl.coef_sel = rre_pkg::REG_FIRST_B0;
        ctl.opd_sel  = rre_pkg::OPD_X;
        ctl.chan     = chan_reg;
        case (state_reg)
            rre_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    state_next = rre_pkg::ST_RUN;
                    step_next  = '0;
                    chan_next  = 1'b0;
                end
            end
            rre_pkg::ST_RUN:
            begin
                // each product takes two passes, low then high operand half;
                // the product is registered before it is accumulated
                case (step_reg)
                    5'd0, 5'd1:
                    begin
                        ctl.mac.issue = 1'b1;
                        ctl.mac.first = (step_reg == 5'd0);
                        ctl.coef_sel  = rre_pkg::REG_FIRST_B0;
                        ctl.opd_sel   = rre_pkg::OPD_X;
                    end
                    5'd2, 5'd3:
                    begin
                        ctl.mac.issue = 1'b1;
                        ctl.coef_sel  = rre_pkg::REG_FIRST_B1;
                        ctl.opd_sel   = rre_pkg::OPD_XP;
                    end
                    5'd4, 5'd5:
                    begin
                        ctl.mac.issue = 1'b1;
                        ctl.mac.neg   = 1'b1;
                        ctl.coef_sel  = rre_pkg::REG_FIRST_A1;
                        ctl.opd_sel   = rre_pkg::OPD_Y1P;
                    end
                    5'd6, 5'd7:
                    begin
                        // second section starts on terms that need no new y1
                        ctl.mac.issue = 1'b1;
                        ctl.mac.first = (step_reg == 5'd6);
                        ctl.coef_sel  = rre_pkg::REG_SECOND_B1;
                        ctl.opd_sel   = rre_pkg::OPD_Y1P;
                        ctl.store_y1  = (step_reg == 5'd7);
                    end
                    5'd8, 5'd9:
                    begin
                        ctl.mac.issue = 1'b1;
                        ctl.mac.neg   = 1'b1;
                        ctl.coef_sel  = rre_pkg::REG_SECOND_A1;
                        ctl.opd_sel   = rre_pkg::OPD_Y2P;
                    end
                    5'd10, 5'd11:
                    begin
                        ctl.mac.issue = 1'b1;
                        ctl.coef_sel  = rre_pkg::REG_SECOND_B0;
                        ctl.opd_sel   = rre_pkg::OPD_Y1;
                    end
                    5'd13:
                    begin
                        ctl.store_y2 = 1'b1;
                    end
                    5'd14, 5'd15:
                    begin
                        ctl.mac.issue = 1'b1;
                        ctl.mac.first = (step_reg == 5'd14);
                        ctl.coef_sel  = rre_pkg::REG_OUTPUT_GAIN;
                        ctl.opd_sel   = rre_pkg::OPD_Y2;
                    end
                    5'd17:
                    begin
                        ctl.store_res = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                ctl.mac.hi = step_reg[0];
                if (step_reg == STEP_W'(STEP_LAST))
                begin
                    step_next = '0;
                    if (chan_reg)
                    begin
                        state_next = rre_pkg::ST_HOLD;
                    end
                    else
                    begin
                        chan_next = 1'b1;
                    end
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            rre_pkg::ST_HOLD:
            begin
                if (slot_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = rre_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rre_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/stereo_riaa_equalizer.sv
// Stereo RIAA de-emphasis: each channel runs through two first-order IIR
// sections (y = b0*x + b1*x1 - a1*y1) and a gain, with Q1.23 samples,
// Q5.27 coefficients and 40-bit internal values; section results saturate to
// the internal range and outputs to the sample range. An item passes the idle
// accept state, 18 steps per channel and a hold state that waits for a free
// output register and hands it the result before the next ready. The steps
// come from the single shared multiplier, which forms each of the seven
// products per channel in two passes over its operand halves. A finished
// result waits in the output register while the next item is taken. The user
// must write coefficients through cfg_we/cfg_index/cfg_data only while idle;
// the block does not enforce it. History clears after an item with last_of_block set.
`timescale 1ns / 1ps
`default_nettype none

module stereo_riaa_equalizer #(
    parameter int SAMPLE_WIDTH   = rre_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH     = rre_pkg::COEF_WIDTH_DEF,
    parameter int INTERNAL_WIDTH = rre_pkg::INTERNAL_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [rre_pkg::REG_INDEX_W-1:0]   cfg_index,
    input  wire logic [COEF_WIDTH-1:0]             cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    left_sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    right_sample,
    input  wire logic                              last_of_block,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]         left_out,
    output logic signed [SAMPLE_WIDTH-1:0]         right_out
);

    rre_pkg::seq_ctl_t ctl;
    logic                              in_fire;
    logic                              slot_free;
    logic signed [COEF_WIDTH-1:0]      coef;
    logic signed [INTERNAL_WIDTH-1:0]  opd;
    logic signed [INTERNAL_WIDTH-1:0]  y_int;
    logic signed [SAMPLE_WIDTH-1:0]    y_smp;
    logic signed [SAMPLE_WIDTH-1:0]    x_cur;

    logic signed [SAMPLE_WIDTH-1:0]    left_in_reg;
    logic signed [SAMPLE_WIDTH-1:0]    right_in_reg;
    logic                              last_reg;
    logic signed [SAMPLE_WIDTH-1:0]    xh_reg  [2];
    logic signed [INTERNAL_WIDTH-1:0]  y1h_reg [2];
    logic signed [INTERNAL_WIDTH-1:0]  y2h_reg [2];
    logic signed [INTERNAL_WIDTH-1:0]  y1_reg;
    logic signed [INTERNAL_WIDTH-1:0]  y2_reg;
    logic signed [SAMPLE_WIDTH-1:0]    left_res_reg;
    logic signed [SAMPLE_WIDTH-1:0]    right_res_reg;
    logic signed [SAMPLE_WIDTH-1:0]    left_out_reg;
    logic signed [SAMPLE_WIDTH-1:0]    right_out_reg;
    logic                              out_valid_reg;

    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    rre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .slot_free (slot_free),
        .in_ready  (in_ready),
        .ctl       (ctl)
    );

    rre_cfg #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .sel   (ctl.coef_sel),
        .coef  (coef)
    );

    rre_mac #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_WIDTH     (COEF_WIDTH),
        .INTERNAL_WIDTH (INTERNAL_WIDTH)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (ctl.mac),
        .coef  (coef),
        .opd   (opd),
        .y_int (y_int),
        .y_smp (y_smp)
    );

    assign x_cur = ctl.chan ? right_in_reg : left_in_reg;

    always_comb
    begin
        case (ctl.opd_sel)
            rre_pkg::OPD_X:   opd = INTERNAL_WIDTH'(x_cur);
            rre_pkg::OPD_XP:  opd = INTERNAL_WIDTH'(xh_reg[ctl.chan]);
            rre_pkg::OPD_Y1P: opd = y1h_reg[ctl.chan];
            rre_pkg::OPD_Y2P: opd = y2h_reg[ctl.chan];
            rre_pkg::OPD_Y1:  opd = y1_reg;
            rre_pkg::OPD_Y2:  opd = y2_reg;
            default:          opd = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            left_in_reg  <= left_sample;
            right_in_reg <= right_sample;
        end
        if (ctl.store_y1)
        begin
            y1_reg <= y_int;
        end
        if (ctl.store_y2)
        begin
            y2_reg <= y_int;
        end
        if (ctl.store_res)
        begin
            if (ctl.chan)
            begin
                right_res_reg <= y_smp;
            end
            else
            begin
                left_res_reg <= y_smp;
            end
        end
        if (ctl.commit)
        begin
            left_out_reg  <= left_res_reg;
            right_out_reg <= right_res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < 2; c++)
            begin
                xh_reg[c]  <= '0;
                y1h_reg[c] <= '0;
                y2h_reg[c] <= '0;
            end
        end
        else
        begin
            if (in_fire)
            begin
                last_reg <= last_of_block;
            end
            if (ctl.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ctl.store_res)
            begin
                // end of block wipes both channels after the right one
                if (ctl.chan && last_reg)
                begin
                    for (int c = 0; c < 2; c++)
                    begin
                        xh_reg[c]  <= '0;
                        y1h_reg[c] <= '0;
                        y2h_reg[c] <= '0;
                    end
                end
                else
                begin
                    xh_reg[ctl.chan]  <= x_cur;
                    y1h_reg[ctl.chan] <= y1_reg;
                    y2h_reg[ctl.chan] <= y2_reg;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input ready right after an accepted item");

    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> (!out_valid_reg || out_ready))
        else $error("result overwrote an item still waiting at the output");

    a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.store_res && ctl.chan && last_reg) |=>
            (xh_reg[0] == '0 && xh_reg[1] == '0 && y1h_reg[0] == '0 &&
             y1h_reg[1] == '0 && y2h_reg[0] == '0 && y2h_reg[1] == '0))
        else $error("history not cleared at end of block");

endmodule

`default_nettype wire
